>>> hw/rtl/hfs_pkg.sv
package hfs_pkg;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_SIZE,
    PH_SKIP,
    PH_CONTENT,
    PH_DONE
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  // configuration register indexes
  localparam logic REG_SEARCH_TYPE = 1'b0;
  localparam logic REG_SCAN_LENGTH = 1'b1;

  // length nibble escapes for explicit size bytes
  localparam logic [3:0] LEN_ONE_BYTE   = 4'hD;
  localparam logic [3:0] LEN_TWO_BYTES  = 4'hE;
  localparam logic [3:0] LEN_FOUR_BYTES = 4'hF;

  localparam logic [31:0] MAX_VALUE_BYTES = 32'd4;
  localparam logic [31:0] POS_MAX         = 32'hFFFF_FFFF;

endpackage

>>> hw/rtl/header_field_scanner.sv
// output: a result is loaded into the output register when the byte that
// completes it is accepted
// throughput: one byte per cycle; the per-byte field decode and the output register
// set the rate, and input ready drops only while a result waits unaccepted
// reset: synchronous active-high rst clears the scan state, both config registers
// and the output valid
module header_field_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] field_offset,
  output logic [31:0] content_offset,
  output logic [31:0] content_size,
  output logic [31:0] field_value
);

  logic [15:0] search_type;
  logic [31:0] scan_length;

  hfs_pkg::phase_t phase, phase_next;
  logic [31:0] position, position_next;
  logic [2:0]  header_index, header_index_next;
  logic        match_flag, match_flag_next;
  logic [31:0] size_accumulator, size_accumulator_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [31:0] head_position, head_position_next;
  logic [31:0] value_accumulator, value_accumulator_next;
  logic [2:0]  content_remaining, content_remaining_next;
  logic [31:0] start_position, start_position_next;

  logic        in_accept;
  logic        emit;
  logic [1:0]  emit_status;
  logic [31:0] emit_field_offset;
  logic [31:0] emit_content_offset;
  logic [31:0] emit_content_size;
  logic [31:0] emit_value;
  logic [31:0] pos_inc;
  logic        hdr_done;
  logic [31:0] size_new;
  logic [31:0] value_new;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign pos_inc   = (position == hfs_pkg::POS_MAX) ? position : position + 32'd1;

  always_comb begin
    phase_next             = phase;
    position_next          = pos_inc;
    header_index_next      = header_index;
    match_flag_next        = match_flag;
    size_accumulator_next  = size_accumulator;
    skip_remaining_next    = skip_remaining;
    head_position_next     = head_position;
    value_accumulator_next = value_accumulator;
    content_remaining_next = content_remaining;
    start_position_next    = start_position;
    emit                   = 1'b0;
    emit_status            = hfs_pkg::ST_NOT_FOUND;
    emit_field_offset      = '0;
    emit_content_offset    = '0;
    emit_content_size      = '0;
    emit_value             = '0;
    hdr_done               = 1'b0;
    size_new               = size_accumulator;
    value_new              = {value_accumulator[23:0], data_byte};

    unique case (phase)
      hfs_pkg::PH_HEAD0: begin
        if (position >= scan_length) begin
          emit       = 1'b1;
          phase_next = hfs_pkg::PH_DONE;
        end else begin
          head_position_next = position;
          match_flag_next    = (data_byte == search_type[15:8]);
          phase_next         = hfs_pkg::PH_HEAD1;
        end
      end
      hfs_pkg::PH_HEAD1: begin
        match_flag_next       = match_flag && (data_byte[7:4] == search_type[7:4]);
        size_accumulator_next = '0;
        unique case (data_byte[3:0])
          hfs_pkg::LEN_ONE_BYTE: begin
            header_index_next = 3'd1;
            phase_next        = hfs_pkg::PH_SIZE;
          end
          hfs_pkg::LEN_TWO_BYTES: begin
            header_index_next = 3'd2;
            phase_next        = hfs_pkg::PH_SIZE;
          end
          hfs_pkg::LEN_FOUR_BYTES: begin
            header_index_next = 3'd4;
            phase_next        = hfs_pkg::PH_SIZE;
          end
          default: begin
            size_new              = {28'd0, data_byte[3:0]};
            size_accumulator_next = size_new;
            hdr_done              = 1'b1;
          end
        endcase
      end
      hfs_pkg::PH_SIZE: begin
        size_new              = {size_accumulator[23:0], data_byte};
        size_accumulator_next = size_new;
        header_index_next     = header_index - 3'd1;
        if (header_index == 3'd1) begin
          hdr_done = 1'b1;
        end
      end
      hfs_pkg::PH_SKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) begin
          phase_next = hfs_pkg::PH_HEAD0;
        end
      end
      hfs_pkg::PH_CONTENT: begin
        value_accumulator_next = value_new;
        content_remaining_next = content_remaining - 3'd1;
        if (content_remaining == 3'd1) begin
          emit                = 1'b1;
          emit_status         = hfs_pkg::ST_FOUND;
          emit_field_offset   = head_position;
          emit_content_offset = start_position;
          emit_content_size   = size_accumulator;
          emit_value          = value_new;
          phase_next          = hfs_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // header complete: either report, read up to four content bytes, or skip
    if (hdr_done) begin
      if (match_flag_next) begin
        start_position_next = pos_inc;
        if (size_new > hfs_pkg::MAX_VALUE_BYTES) begin
          emit                = 1'b1;
          emit_status         = hfs_pkg::ST_TOO_LONG;
          emit_field_offset   = head_position;
          emit_content_offset = pos_inc;
          emit_content_size   = size_new;
          phase_next          = hfs_pkg::PH_DONE;
        end else if (size_new == 32'd0) begin
          emit                = 1'b1;
          emit_status         = hfs_pkg::ST_FOUND;
          emit_field_offset   = head_position;
          emit_content_offset = pos_inc;
          phase_next          = hfs_pkg::PH_DONE;
        end else begin
          content_remaining_next = size_new[2:0];
          value_accumulator_next = '0;
          phase_next             = hfs_pkg::PH_CONTENT;
        end
      end else begin
        skip_remaining_next = size_new;
        phase_next = (size_new != 32'd0) ? hfs_pkg::PH_SKIP : hfs_pkg::PH_HEAD0;
      end
    end

    // end of stream: report not found if nothing was reported, then restart
    if (last_byte) begin
      if (!emit && phase_next != hfs_pkg::PH_DONE) begin
        emit = 1'b1;
      end
      phase_next             = hfs_pkg::PH_HEAD0;
      position_next          = '0;
      header_index_next      = '0;
      match_flag_next        = 1'b0;
      size_accumulator_next  = '0;
      skip_remaining_next    = '0;
      head_position_next     = '0;
      value_accumulator_next = '0;
      content_remaining_next = '0;
      start_position_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_type <= '0;
      scan_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hfs_pkg::REG_SEARCH_TYPE: search_type <= cfg_data[15:0];
        hfs_pkg::REG_SCAN_LENGTH: scan_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= hfs_pkg::PH_HEAD0;
      position          <= '0;
      header_index      <= '0;
      match_flag        <= 1'b0;
      size_accumulator  <= '0;
      skip_remaining    <= '0;
      head_position     <= '0;
      value_accumulator <= '0;
      content_remaining <= '0;
      start_position    <= '0;
    end else if (in_accept) begin
      phase             <= phase_next;
      position          <= position_next;
      header_index      <= header_index_next;
      match_flag        <= match_flag_next;
      size_accumulator  <= size_accumulator_next;
      skip_remaining    <= skip_remaining_next;
      head_position     <= head_position_next;
      value_accumulator <= value_accumulator_next;
      content_remaining <= content_remaining_next;
      start_position    <= start_position_next;
    end
  end

  // output register, refilled in the same cycle its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      status         <= emit_status;
      field_offset   <= emit_field_offset;
      content_offset <= emit_content_offset;
      content_size   <= emit_content_size;
      field_value    <= emit_value;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == hfs_pkg::ST_FOUND || status == hfs_pkg::ST_NOT_FOUND ||
                   status == hfs_pkg::ST_TOO_LONG))
    else $error("undefined status code on output");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != hfs_pkg::ST_FOUND) |-> (field_value == 32'd0))
    else $error("nonzero value with non-found status");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == hfs_pkg::ST_NOT_FOUND) |->
      (field_offset == 32'd0 && content_offset == 32'd0 && content_size == 32'd0))
    else $error("not found result carries offsets");

  a_content_count: assert property (@(posedge clk) disable iff (rst)
    (phase == hfs_pkg::PH_CONTENT) |-> (content_remaining != 3'd0 && content_remaining <= 3'd4))
    else $error("content byte count out of range");

  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    (phase == hfs_pkg::PH_SKIP) |-> (skip_remaining != 32'd0))
    else $error("skipping with no bytes left");

endmodule
